@@ rtl/bfgr_pkg.sv @@
// ----------------------------------------------------------------------------
// bfgr_pkg
// Shared types, codes and defaults of the bitmap font glyph renderer.
// ----------------------------------------------------------------------------
package bfgr_pkg;

   // default sizes of the font stores
   localparam int MAX_ROWS_DEF         = 32;
   localparam int STRIKE_ROW_WORDS_DEF = 64;
   localparam int GLYPH_MAX_WIDTH_DEF  = 32;
   localparam int TABLE_ENTRIES_DEF    = 258;

   // fixed widths
   localparam int ROW_W   = 6;   // glyph row counter, holds up to 63 rows
   localparam int COL_W   = 13;  // strike column of a 16-bit bit location plus two words
   localparam int CSR_DW  = 10;  // widest configuration register
   localparam int WIN_W   = 48;  // three strike words cover any 32-bit row slice

   typedef enum logic [2:0] {
      CMD_STRIKE = 3'd0,
      CMD_LOC    = 3'd1,
      CMD_OW     = 3'd2,
      CMD_START  = 3'd3,
      CMD_CHAR   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_FONT_KIND    = 3'd0,
      CSR_FIRST_CODE   = 3'd1,
      CSR_LAST_CODE    = 3'd2,
      CSR_MAX_WIDTH    = 3'd3,
      CSR_KERN_SHIFT   = 3'd4,
      CSR_ASCENT_ROWS  = 3'd5,
      CSR_LINE_ADVANCE = 3'd6,
      CSR_GLYPH_ROWS   = 3'd7
   } csr_index_type;

   localparam logic [1:0] KIND_FIXED  = 2'd1;
   localparam logic [1:0] KIND_NOIMG  = 2'd2;
   localparam logic       RK_ROW      = 1'b0;
   localparam logic       RK_DONE     = 1'b1;
   localparam logic [7:0] CODE_NL     = 8'd10;
   localparam logic [15:0] OW_MISSING = 16'hFFFF;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_OW_RD  = 9'b000000010,
      ST_OW_CHK = 9'b000000100,
      ST_LOC_A  = 9'b000001000,
      ST_LOC_B  = 9'b000010000,
      ST_LOC_C  = 9'b000100000,
      ST_ROW    = 9'b001000000,
      ST_ADV    = 9'b010000000,
      ST_FIN    = 9'b100000000
   } state_type;

   typedef struct packed {
      logic        strike_we;
      logic        loc_we;
      logic        ow_we;
      logic [8:0]  index;
      logic [4:0]  row;
      logic [15:0] value;
   } store_wr_type;

endpackage

@@ rtl/bfgr_font_store.sv @@
// ----------------------------------------------------------------------------
// bfgr_font_store
// Strike, location and offset-width memories with one registered read each.
// ----------------------------------------------------------------------------
module bfgr_font_store
   import bfgr_pkg::*;
#(
   parameter int MAX_ROWS         = MAX_ROWS_DEF,
   parameter int STRIKE_ROW_WORDS = STRIKE_ROW_WORDS_DEF,
   parameter int TABLE_ENTRIES    = TABLE_ENTRIES_DEF
) (
   input  logic               clock,
   input  store_wr_type       wr,
   input  logic [ROW_W-1:0]   st_rd_row,
   input  logic [COL_W-1:0]   st_rd_col,
   input  logic [8:0]         loc_rd_idx,
   input  logic [8:0]         ow_rd_idx,
   output logic [15:0]        st_q,
   output logic [15:0]        loc_q,
   output logic [15:0]        ow_q
);

   localparam int ST_DEPTH = MAX_ROWS * STRIKE_ROW_WORDS;
   localparam int ST_AW    = $clog2(ST_DEPTH > 1 ? ST_DEPTH : 2);
   localparam int LOC_AW   = $clog2(TABLE_ENTRIES);
   localparam int OW_DEPTH = TABLE_ENTRIES - 1;
   localparam int OW_AW    = $clog2(OW_DEPTH > 1 ? OW_DEPTH : 2);

   logic [15:0] st_mem_ff  [ST_DEPTH];
   logic [15:0] loc_mem_ff [TABLE_ENTRIES];
   logic [15:0] ow_mem_ff  [OW_DEPTH];

   logic [15:0] st_q_ff, loc_q_ff, ow_q_ff;
   logic        st_ok_ff, loc_ok_ff, ow_ok_ff;

   logic             st_wr_ok, loc_wr_ok, ow_wr_ok;
   logic             st_rd_ok, loc_rd_ok, ow_rd_ok;
   logic [ST_AW-1:0] st_wr_addr, st_rd_addr;

   assign st_wr_ok  = wr.strike_we && (int'(wr.index) < STRIKE_ROW_WORDS)
                      && (int'(wr.row) < MAX_ROWS);
   assign loc_wr_ok = wr.loc_we && (int'(wr.index) < TABLE_ENTRIES);
   assign ow_wr_ok  = wr.ow_we && (int'(wr.index) < OW_DEPTH);

   assign st_rd_ok  = (int'(st_rd_col) < STRIKE_ROW_WORDS) && (int'(st_rd_row) < MAX_ROWS);
   assign loc_rd_ok = int'(loc_rd_idx) < TABLE_ENTRIES;
   assign ow_rd_ok  = int'(ow_rd_idx) < OW_DEPTH;

   assign st_wr_addr = ST_AW'(int'(wr.row) * STRIKE_ROW_WORDS + int'(wr.index));
   assign st_rd_addr = ST_AW'(int'(st_rd_row) * STRIKE_ROW_WORDS + int'(st_rd_col));

   always_ff @(posedge clock) begin
      if (st_wr_ok) begin
         st_mem_ff[st_wr_addr] <= wr.value;
      end
      if (loc_wr_ok) begin
         loc_mem_ff[wr.index[LOC_AW-1:0]] <= wr.value;
      end
      if (ow_wr_ok) begin
         ow_mem_ff[wr.index[OW_AW-1:0]] <= wr.value;
      end
   end

   always_ff @(posedge clock) begin
      st_ok_ff  <= st_rd_ok;
      loc_ok_ff <= loc_rd_ok;
      ow_ok_ff  <= ow_rd_ok;
      if (st_rd_ok) begin
         st_q_ff <= st_mem_ff[st_rd_addr];
      end
      if (loc_rd_ok) begin
         loc_q_ff <= loc_mem_ff[loc_rd_idx[LOC_AW-1:0]];
      end
      if (ow_rd_ok) begin
         ow_q_ff <= ow_mem_ff[ow_rd_idx[OW_AW-1:0]];
      end
   end

   // out-of-range reads give zero
   assign st_q  = st_ok_ff  ? st_q_ff  : 16'd0;
   assign loc_q = loc_ok_ff ? loc_q_ff : 16'd0;
   assign ow_q  = ow_ok_ff  ? ow_q_ff  : 16'd0;

endmodule

@@ rtl/bfgr_row_shift.sv @@
// ----------------------------------------------------------------------------
// bfgr_row_shift
// Shared shift unit: aligns a three-word strike window and masks the width.
// ----------------------------------------------------------------------------
module bfgr_row_shift
   import bfgr_pkg::*;
(
   input  logic [WIN_W-1:0] window,
   input  logic [3:0]       shift,
   input  logic [5:0]       width,
   output logic [31:0]      bits
);

   logic [WIN_W-1:0] aligned;
   logic [31:0]      mask;

   assign aligned = window << shift;
   // keep the leftmost width bits, width of 32 keeps all
   assign mask    = ~(32'hFFFF_FFFF >> width);
   assign bits    = aligned[WIN_W-1 -: 32] & mask;

endmodule

@@ rtl/bitmap_font_glyph_renderer_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_font_glyph_renderer_top
// Text renderer over a loaded bitmap font strike.
//
// A command word is taken when start is high and busy is low. Load commands
// (strike word, location, offset-width) and start text leave busy low and
// give no result. A character keeps busy high until its last result word.
// Results appear on the rsp_ ports for one cycle each, marked by rsp_valid;
// the receiver cannot stall, so results are never held back.
// Newline: the finished word comes straight from ST_FIN, with no font read.
// Measure or no-image character: ST_OW_RD, ST_OW_CHK, ST_ADV and ST_FIN;
// the missing glyph fallback rereads the offset-width table in both ST_OW_ states.
// Drawn character: also ST_LOC_A to ST_LOC_C, then ST_ROW for each glyph row;
// each row costs three strike memory reads through the one strike read port
// plus the shift-and-mask step.
// Configuration writes on csr_ take effect at the next edge and must only
// happen while busy is low. Reset clears pen, extent, mode and configuration;
// the font memories are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_renderer_top
   import bfgr_pkg::*;
#(
   parameter int MAX_ROWS         = MAX_ROWS_DEF,
   parameter int STRIKE_ROW_WORDS = STRIKE_ROW_WORDS_DEF,
   parameter int GLYPH_MAX_WIDTH  = GLYPH_MAX_WIDTH_DEF,
   parameter int TABLE_ENTRIES    = TABLE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic [7:0]         req_char_code,
   input  logic               req_draw_mode,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [8:0]         req_table_index,
   input  logic [4:0]         req_strike_row,
   input  logic [15:0]        req_table_value,
   output logic               rsp_valid,
   output logic               rsp_result_kind,
   output logic signed [15:0] rsp_row_x,
   output logic signed [15:0] rsp_row_y,
   output logic [31:0]        rsp_row_bits,
   output logic signed [15:0] rsp_text_extent,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [CSR_DW-1:0]  csr_wdata
);

   localparam int GLYPH_CAP = GLYPH_MAX_WIDTH < 32 ? GLYPH_MAX_WIDTH : 32;

   // configuration
   logic [1:0] font_kind_ff;
   logic [7:0] first_code_ff, last_code_ff, max_width_ff, kern_shift_ff, ascent_ff;
   logic [9:0] line_adv_ff;
   logic [5:0] glyph_rows_ff;

   // control and pen state
   state_type   state_ff, state_in;
   logic [15:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic [15:0] line_start_ff, line_start_in, far_ff, far_in;
   logic        drawing_ff, drawing_in;
   logic        retry_ff, retry_in, nl_ff, nl_in;
   logic [1:0]  wcnt_ff, wcnt_in;
   logic [ROW_W-1:0] by_ff, by_in, rows_ff, rows_in;

   // per-character working registers
   logic [8:0]  idx_ff, idx_in, missing_ff, missing_in;
   logic [15:0] ow_ff, ow_in, loc_ff, loc_in;
   logic [5:0]  width_ff, width_in;
   logic [15:0] word0_ff, word0_in, word1_ff, word1_in;
   logic [15:0] rx_ff, rx_in, ry_ff, ry_in;

   // result word
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in, rsp_last_ff, rsp_last_in;
   logic [15:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_ext_ff, rsp_ext_in;
   logic [31:0] rsp_bits_ff, rsp_bits_in;

   logic               accept;
   store_wr_type       wr;
   logic [8:0]         loc_rd_idx;
   logic [COL_W-1:0]   st_rd_col;
   logic [15:0]        st_q, loc_q, ow_q;
   logic [31:0]        row_bits;
   logic [7:0]         offset;
   logic [16:0]        loc_diff;
   logic [ROW_W-1:0]   rows_cap;
   logic               code_in_range;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign wr.strike_we = accept && (req_cmd == CMD_STRIKE);
   assign wr.loc_we    = accept && (req_cmd == CMD_LOC);
   assign wr.ow_we     = accept && (req_cmd == CMD_OW);
   assign wr.index     = req_table_index;
   assign wr.row       = req_strike_row;
   assign wr.value     = req_table_value;

   assign loc_rd_idx = (state_ff == ST_LOC_A) ? idx_ff : 9'(idx_ff + 9'd1);
   assign st_rd_col  = COL_W'(loc_ff[15:4]) + COL_W'(wcnt_ff);

   bfgr_font_store #(
      .MAX_ROWS         (MAX_ROWS),
      .STRIKE_ROW_WORDS (STRIKE_ROW_WORDS),
      .TABLE_ENTRIES    (TABLE_ENTRIES)
   ) u_store (
      .clock      (clock),
      .wr         (wr),
      .st_rd_row  (by_ff),
      .st_rd_col  (st_rd_col),
      .loc_rd_idx (loc_rd_idx),
      .ow_rd_idx  (idx_ff),
      .st_q       (st_q),
      .loc_q      (loc_q),
      .ow_q       (ow_q)
   );

   bfgr_row_shift u_shift (
      .window ({word0_ff, word1_ff, st_q}),
      .shift  (loc_ff[3:0]),
      .width  (width_ff),
      .bits   (row_bits)
   );

   assign offset        = ow_ff[15:8] + kern_shift_ff;
   assign loc_diff      = {1'b0, loc_q} - {1'b0, loc_ff};
   assign rows_cap      = (int'(glyph_rows_ff) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : glyph_rows_ff;
   assign code_in_range = (req_char_code >= first_code_ff) && (req_char_code <= last_code_ff);

   always_comb begin
      state_in      = state_ff;
      pen_x_in      = pen_x_ff;
      pen_y_in      = pen_y_ff;
      line_start_in = line_start_ff;
      far_in        = far_ff;
      drawing_in    = drawing_ff;
      retry_in      = retry_ff;
      nl_in         = nl_ff;
      wcnt_in       = wcnt_ff;
      by_in         = by_ff;
      rows_in       = rows_ff;
      idx_in        = idx_ff;
      missing_in    = missing_ff;
      ow_in         = ow_ff;
      loc_in        = loc_ff;
      width_in      = width_ff;
      word0_in      = word0_ff;
      word1_in      = word1_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_ext_in    = rsp_ext_ff;
      rsp_bits_in   = rsp_bits_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_START: begin
                     drawing_in    = req_draw_mode;
                     pen_x_in      = req_draw_mode ? req_pos_x : 16'd0;
                     pen_y_in      = req_draw_mode ? req_pos_y : 16'd0;
                     line_start_in = pen_x_in;
                     far_in        = pen_x_in;
                  end
                  CMD_CHAR: begin
                     missing_in = (last_code_ff >= first_code_ff)
                                  ? 9'({1'b0, last_code_ff} - {1'b0, first_code_ff} + 9'd1)
                                  : 9'd0;
                     idx_in     = code_in_range
                                  ? {1'b0, req_char_code - first_code_ff} : missing_in;
                     retry_in   = 1'b0;
                     if (req_char_code == CODE_NL) begin
                        nl_in    = 1'b1;
                        pen_x_in = line_start_ff;
                        pen_y_in = pen_y_ff + {6'd0, line_adv_ff};
                        state_in = ST_FIN;
                     end else begin
                        nl_in    = 1'b0;
                        state_in = ST_OW_RD;
                     end
                  end
                  default: begin
                     // loads go straight to the stores, other codes are dropped
                  end
               endcase
            end
         end
         ST_OW_RD: begin
            state_in = ST_OW_CHK;
         end
         ST_OW_CHK: begin
            ow_in = ow_q;
            if (ow_q == OW_MISSING && !retry_ff) begin
               // entry marked missing: reread at the missing glyph
               retry_in = 1'b1;
               idx_in   = missing_ff;
               state_in = ST_OW_RD;
            end else if (drawing_ff && font_kind_ff < KIND_NOIMG) begin
               state_in = ST_LOC_A;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_LOC_A: begin
            rx_in    = pen_x_ff + {8'd0, offset};
            ry_in    = pen_y_ff - {8'd0, ascent_ff};
            state_in = ST_LOC_B;
         end
         ST_LOC_B: begin
            loc_in   = loc_q;
            state_in = ST_LOC_C;
         end
         ST_LOC_C: begin
            if (loc_diff[16] || loc_diff == 17'd0) begin
               width_in = 6'd0;
            end else if (loc_diff > 17'(GLYPH_CAP)) begin
               width_in = 6'(GLYPH_CAP);
            end else begin
               width_in = loc_diff[5:0];
            end
            rows_in  = rows_cap;
            by_in    = '0;
            wcnt_in  = 2'd0;
            state_in = (rows_cap == '0) ? ST_ADV : ST_ROW;
         end
         ST_ROW: begin
            wcnt_in = 2'(wcnt_ff + 2'd1);
            case (wcnt_ff)
               2'd1: word0_in = st_q;
               2'd2: word1_in = st_q;
               2'd3: begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = RK_ROW;
                  rsp_last_in  = 1'b0;
                  rsp_x_in     = rx_ff;
                  rsp_y_in     = ry_ff + {10'd0, by_ff};
                  rsp_bits_in  = row_bits;
                  rsp_ext_in   = 16'd0;
                  by_in        = ROW_W'(by_ff + 1'b1);
                  if (by_in == rows_ff) begin
                     state_in = ST_ADV;
                  end
               end
               default: begin
                  // first strike word is being read
               end
            endcase
         end
         ST_ADV: begin
            pen_x_in = pen_x_ff + {8'd0, (font_kind_ff == KIND_FIXED) ? max_width_ff
                                                                      : ow_ff[7:0]};
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!nl_ff && ($signed(pen_x_ff) > $signed(far_ff))) begin
               far_in = pen_x_ff;
            end
            rsp_valid_in = 1'b1;
            rsp_kind_in  = RK_DONE;
            rsp_last_in  = 1'b1;
            rsp_x_in     = pen_x_ff;
            rsp_y_in     = pen_y_ff;
            rsp_bits_in  = 32'd0;
            rsp_ext_in   = far_in - line_start_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pen_x_ff      <= 16'd0;
         pen_y_ff      <= 16'd0;
         line_start_ff <= 16'd0;
         far_ff        <= 16'd0;
         drawing_ff    <= 1'b0;
         retry_ff      <= 1'b0;
         nl_ff         <= 1'b0;
         wcnt_ff       <= 2'd0;
         by_ff         <= '0;
         rows_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pen_x_ff      <= pen_x_in;
         pen_y_ff      <= pen_y_in;
         line_start_ff <= line_start_in;
         far_ff        <= far_in;
         drawing_ff    <= drawing_in;
         retry_ff      <= retry_in;
         nl_ff         <= nl_in;
         wcnt_ff       <= wcnt_in;
         by_ff         <= by_in;
         rows_ff       <= rows_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      missing_ff  <= missing_in;
      ow_ff       <= ow_in;
      loc_ff      <= loc_in;
      width_ff    <= width_in;
      word0_ff    <= word0_in;
      word1_ff    <= word1_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_ext_ff  <= rsp_ext_in;
      rsp_bits_ff <= rsp_bits_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         font_kind_ff  <= 2'd0;
         first_code_ff <= 8'd0;
         last_code_ff  <= 8'd255;
         max_width_ff  <= 8'd0;
         kern_shift_ff <= 8'd0;
         ascent_ff     <= 8'd0;
         line_adv_ff   <= 10'd0;
         glyph_rows_ff <= 6'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FONT_KIND:    font_kind_ff  <= csr_wdata[1:0];
            CSR_FIRST_CODE:   first_code_ff <= csr_wdata[7:0];
            CSR_LAST_CODE:    last_code_ff  <= csr_wdata[7:0];
            CSR_MAX_WIDTH:    max_width_ff  <= csr_wdata[7:0];
            CSR_KERN_SHIFT:   kern_shift_ff <= csr_wdata[7:0];
            CSR_ASCENT_ROWS:  ascent_ff     <= csr_wdata[7:0];
            CSR_LINE_ADVANCE: line_adv_ff   <= csr_wdata[9:0];
            CSR_GLYPH_ROWS:   glyph_rows_ff <= csr_wdata[5:0];
            default: begin
               // every index is a register
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_row_x       = rsp_x_ff;
   assign rsp_row_y       = rsp_y_ff;
   assign rsp_row_bits    = rsp_bits_ff;
   assign rsp_text_extent = rsp_ext_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
